@@ rtl/sss_pkg.sv @@
`default_nettype none

package sss_pkg;

   // sequencer size and control tick rate
   localparam int STEPS         = 8;
   localparam int TICKS_PER_SEC = 64;

   // word field widths
   localparam int MODE_W  = 3;
   localparam int STEP_W  = 4;
   localparam int NOTE_W  = 8;
   localparam int TICK_W  = 16;
   localparam int IDX_W   = (STEPS > 1) ? $clog2(STEPS) : 1;

   // configuration registers
   localparam int BPM_W      = 9;
   localparam int SWING_W    = 7;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMPO_BPM     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWING_PERCENT = 1'b1;

   localparam int BPM_MIN     = 30;
   localparam int BPM_MAX     = 300;
   localparam int BPM_RESET   = 120;
   localparam int SWING_MIN   = 50;
   localparam int SWING_MAX   = 75;
   localparam int SWING_RESET = 50;
   localparam int SWING_DIV   = 100;
   localparam int SEC_PER_MIN = 60;
   localparam int LEN_MIN     = 2;
   localparam int LEN_MAX     = 65535;
   localparam int NOTE_BASE   = 36;

   // timing arithmetic sizes
   localparam int DIVIDEND_MAX = TICKS_PER_SEC * SEC_PER_MIN + BPM_MAX / 2;
   localparam int DIV_W        = $clog2(DIVIDEND_MAX + 1);
   localparam int DIV_CNT_W    = $clog2(DIV_W);
   localparam int BASE_MAX     = DIVIDEND_MAX / BPM_MIN;
   localparam int SW_W         = $clog2(SWING_MAX - SWING_MIN + 1);
   localparam int PROD_MAX     = BASE_MAX * (SWING_MAX - SWING_MIN);
   localparam int PROD_W       = $clog2(PROD_MAX + 1);

   // x / 100 as (x * RECIP_100) >> RECIP_SHIFT, exact for x up to 43690
   localparam int RECIP_SHIFT  = 19;
   localparam int RECIP_100    = ((1 << RECIP_SHIFT) + SWING_DIV - 1) / SWING_DIV;
   localparam int RECIP_W      = $clog2(RECIP_100 + 1);

   // step length at the reset tempo, no swing
   localparam int BASE_RESET_RAW = (TICKS_PER_SEC * SEC_PER_MIN + BPM_RESET / 2) / BPM_RESET;
   localparam int BASE_RESET     = (BASE_RESET_RAW < LEN_MIN) ? LEN_MIN : BASE_RESET_RAW;

   typedef enum logic [MODE_W-1:0] {
      MODE_TICK        = 3'd0,
      MODE_RESTART     = 3'd1,
      MODE_SET_GATE    = 3'd2,
      MODE_TOGGLE_GATE = 3'd3,
      MODE_SET_NOTE    = 3'd4,
      MODE_SET_ACCENT  = 3'd5
   } mode_type;

   function automatic logic [NOTE_W-1:0] note_reset(input int i);
      note_reset = NOTE_W'(NOTE_BASE + 2 * i);
   endfunction

endpackage

`default_nettype wire

@@ rtl/swing_step_sequencer.sv @@
// Swing step sequencer.
// Input channel (req_*): one word per control-rate tick or edit. mode selects tick,
// restart, set gate, toggle gate, set note or set accent; step_index, note_value and
// flag_value carry the edit. Edits to a step index at or past the step count are
// dropped. Every accepted word gives exactly one result word (rsp_*): whether a new
// step began, and the step, note, gate and accent now playing.
// rsp_valid rises in the cycle after a word is accepted, and a word can be accepted
// in every cycle while no timing recompute runs: the state update and table read sit
// between the input ports and the result register. A held result does not block the
// next word as long as rsp_ready is high in the same cycle; with rsp_ready low, req_ready drops until it is taken.
// Configuration (csr_*): tempo writes are clamped, swing writes clamp csr_wdata[6:0],
// and either starts a timing recompute: a load state, a bit-serial divider for the
// base length, then base floor, multiply, scale by 1/100 and length clamp, during
// which req_ready is low.
// Reset (synchronous) restores the default step table, step 0, 120 bpm and no
// swing, with the timing already valid, so words are taken right after reset.
`default_nettype none

module swing_step_sequencer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sss_pkg::MODE_W-1:0]   req_mode,
   input  logic [sss_pkg::STEP_W-1:0]   req_step_index,
   input  logic [sss_pkg::NOTE_W-1:0]   req_note_value,
   input  logic                         req_flag_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_step_started,
   output logic [sss_pkg::STEP_W-1:0]   rsp_current_step,
   output logic [sss_pkg::NOTE_W-1:0]   rsp_current_note,
   output logic                         rsp_current_gate,
   output logic                         rsp_current_accent,
   input  logic                         csr_write_en,
   input  logic [sss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sss_pkg::*;

   typedef enum logic [2:0] {
      T_IDLE,
      T_LOAD,
      T_DIV,
      T_BASE,
      T_MUL,
      T_SCALE,
      T_LEN
   } timing_state_type;

   // step table and play state
   logic              gate_ff   [STEPS];
   logic              gate_in   [STEPS];
   logic [NOTE_W-1:0] note_ff   [STEPS];
   logic [NOTE_W-1:0] note_in   [STEPS];
   logic              accent_ff [STEPS];
   logic              accent_in [STEPS];
   logic [STEP_W-1:0] pos_ff, pos_in;
   logic [TICK_W-1:0] tick_ff, tick_in;

   // result register
   logic              rsp_valid_ff;
   logic              started_ff, started_in;
   logic [STEP_W-1:0] cur_step_ff;
   logic [NOTE_W-1:0] cur_note_ff;
   logic              cur_gate_ff;
   logic              cur_accent_ff;

   // configuration and timing
   logic [BPM_W-1:0]     bpm_ff, bpm_in;
   logic [SWING_W-1:0]   swing_pct_ff, swing_pct_in;
   timing_state_type     t_state_ff, t_state_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [BPM_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [TICK_W-1:0]    base_ff, base_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [TICK_W-1:0]    swing_ff, swing_in;
   logic [TICK_W-1:0]    len_even_ff, len_even_in;
   logic [TICK_W-1:0]    len_odd_ff, len_odd_in;

   logic                 req_fire;
   logic                 idx_valid;
   logic [TICK_W-1:0]    tick_inc;
   logic [TICK_W-1:0]    step_len;
   logic [IDX_W-1:0]     rd_idx;
   mode_type             mode;

   logic [BPM_W:0]                trial;
   logic [TICK_W+SW_W-1:0]        prod_full;
   logic [SW_W-1:0]               swing_off;
   logic [PROD_W+RECIP_W-1:0]     scaled_full;
   logic [TICK_W:0]               even_sum;
   logic [TICK_W:0]               odd_diff;

   assign req_ready = (t_state_ff == T_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_started   = started_ff;
   assign rsp_current_step   = cur_step_ff;
   assign rsp_current_note   = cur_note_ff;
   assign rsp_current_gate   = cur_gate_ff;
   assign rsp_current_accent = cur_accent_ff;

   // per-word update
   always_comb begin
      mode       = mode_type'(req_mode);
      idx_valid  = ({1'b0, req_step_index} < (STEP_W + 1)'(STEPS));
      tick_inc   = tick_ff + TICK_W'(1);
      step_len   = pos_ff[0] ? len_odd_ff : len_even_ff;
      pos_in     = pos_ff;
      tick_in    = tick_ff;
      started_in = 1'b0;
      for (int i = 0; i < STEPS; i++) begin
         gate_in[i]   = gate_ff[i];
         note_in[i]   = note_ff[i];
         accent_in[i] = accent_ff[i];
      end
      case (mode)
         MODE_TICK: begin
            if (tick_inc >= step_len) begin
               tick_in    = '0;
               started_in = 1'b1;
               pos_in     = (pos_ff == STEP_W'(STEPS - 1)) ? '0 : pos_ff + STEP_W'(1);
            end else begin
               tick_in = tick_inc;
            end
         end
         MODE_RESTART: begin
            pos_in  = '0;
            tick_in = '0;
         end
         MODE_SET_GATE, MODE_TOGGLE_GATE, MODE_SET_NOTE, MODE_SET_ACCENT: begin
            for (int i = 0; i < STEPS; i++) begin
               if (idx_valid && (req_step_index == STEP_W'(i))) begin
                  case (mode)
                     MODE_SET_GATE:    gate_in[i]   = req_flag_value;
                     MODE_TOGGLE_GATE: gate_in[i]   = ~gate_ff[i];
                     MODE_SET_NOTE:    note_in[i]   = req_note_value;
                     MODE_SET_ACCENT:  accent_in[i] = req_flag_value;
                     default: ;
                  endcase
               end
            end
         end
         default: ;
      endcase
      rd_idx = pos_in[IDX_W-1:0];
   end

   // configuration writes and timing recompute
   always_comb begin
      bpm_in       = bpm_ff;
      swing_pct_in = swing_pct_ff;
      t_state_in   = t_state_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      swing_in     = swing_ff;
      len_even_in  = len_even_ff;
      len_odd_in   = len_odd_ff;

      trial       = {rem_ff, dvd_ff[DIV_W-1]};
      swing_off   = SW_W'(swing_pct_ff - SWING_W'(SWING_MIN));
      prod_full   = base_ff * swing_off;
      scaled_full = prod_ff * RECIP_W'(RECIP_100);
      even_sum    = {1'b0, base_ff} + {1'b0, swing_ff};
      odd_diff    = {1'b0, base_ff} - {1'b0, swing_ff};

      case (t_state_ff)
         T_IDLE: ;
         T_LOAD: begin
            dvd_in     = DIV_W'(TICKS_PER_SEC * SEC_PER_MIN) + DIV_W'(bpm_ff >> 1);
            rem_in     = '0;
            div_cnt_in = '0;
            t_state_in = T_DIV;
         end
         T_DIV: begin
            // restoring division, quotient bits shift in behind the dividend
            if (trial >= {1'b0, bpm_ff}) begin
               rem_in = BPM_W'(trial - {1'b0, bpm_ff});
               dvd_in = {dvd_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = trial[BPM_W-1:0];
               dvd_in = {dvd_ff[DIV_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               t_state_in = T_BASE;
            end
         end
         T_BASE: begin
            base_in    = (TICK_W'(dvd_ff) < TICK_W'(LEN_MIN)) ? TICK_W'(LEN_MIN)
                                                             : TICK_W'(dvd_ff);
            t_state_in = T_MUL;
         end
         T_MUL: begin
            prod_in    = prod_full[PROD_W-1:0];
            t_state_in = T_SCALE;
         end
         T_SCALE: begin
            swing_in   = TICK_W'(scaled_full >> RECIP_SHIFT);
            t_state_in = T_LEN;
         end
         T_LEN: begin
            len_even_in = even_sum[TICK_W] ? TICK_W'(LEN_MAX) : even_sum[TICK_W-1:0];
            len_odd_in  = (odd_diff[TICK_W] || (odd_diff[TICK_W-1:0] < TICK_W'(LEN_MIN)))
                          ? TICK_W'(LEN_MIN) : odd_diff[TICK_W-1:0];
            t_state_in  = T_IDLE;
         end
         default: t_state_in = T_IDLE;
      endcase

      // a new write restarts the recompute with the latest values
      if (csr_write_en) begin
         case (csr_index)
            CSR_TEMPO_BPM: begin
               if (csr_wdata < CSR_DATA_W'(BPM_MIN)) begin
                  bpm_in = BPM_W'(BPM_MIN);
               end else if (csr_wdata > CSR_DATA_W'(BPM_MAX)) begin
                  bpm_in = BPM_W'(BPM_MAX);
               end else begin
                  bpm_in = csr_wdata[BPM_W-1:0];
               end
            end
            CSR_SWING_PERCENT: begin
               if (csr_wdata[SWING_W-1:0] < SWING_W'(SWING_MIN)) begin
                  swing_pct_in = SWING_W'(SWING_MIN);
               end else if (csr_wdata[SWING_W-1:0] > SWING_W'(SWING_MAX)) begin
                  swing_pct_in = SWING_W'(SWING_MAX);
               end else begin
                  swing_pct_in = csr_wdata[SWING_W-1:0];
               end
            end
            default: ;
         endcase
         t_state_in = T_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STEPS; i++) begin
            gate_ff[i]   <= 1'b1;
            note_ff[i]   <= note_reset(i);
            accent_ff[i] <= 1'b0;
         end
         pos_ff       <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         bpm_ff       <= BPM_W'(BPM_RESET);
         swing_pct_ff <= SWING_W'(SWING_RESET);
         t_state_ff   <= T_IDLE;
         base_ff      <= TICK_W'(BASE_RESET);
         swing_ff     <= '0;
         len_even_ff  <= TICK_W'(BASE_RESET);
         len_odd_ff   <= TICK_W'(BASE_RESET);
      end else begin
         if (req_fire) begin
            for (int i = 0; i < STEPS; i++) begin
               gate_ff[i]   <= gate_in[i];
               note_ff[i]   <= note_in[i];
               accent_ff[i] <= accent_in[i];
            end
            pos_ff       <= pos_in;
            tick_ff      <= tick_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         bpm_ff       <= bpm_in;
         swing_pct_ff <= swing_pct_in;
         t_state_ff   <= t_state_in;
         base_ff      <= base_in;
         swing_ff     <= swing_in;
         len_even_ff  <= len_even_in;
         len_odd_ff   <= len_odd_in;
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         started_ff    <= started_in;
         cur_step_ff   <= pos_in;
         cur_note_ff   <= note_in[rd_idx];
         cur_gate_ff   <= gate_in[rd_idx];
         cur_accent_ff <= accent_in[rd_idx];
      end
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      prod_ff    <= prod_in;
   end

   // a register write holds off words until the timing is recomputed
   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> !req_ready)
      else $error("word accepted during timing recompute");

   // only a tick can start a step
   a_started_only_tick: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_mode != MODE_TICK)) |=> !rsp_step_started)
      else $error("step start reported for a non-tick word");

   // a step start leaves the tick counter at zero while the result is shown
   a_started_tick_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_step_started) |-> (tick_ff == '0))
      else $error("tick counter not cleared at step start");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_current_step < STEP_W'(STEPS)))
      else $error("current step past step count");

endmodule

`default_nettype wire
